FILE: rtl/core/pgm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants of the slotted page manager.
// ---------------------------------------------------------------------------
package pgm_pkg;

   localparam int DEF_PAGE_BYTES   = 4096;
   localparam int DEF_HEADER_BYTES = 16;
   localparam int DEF_ENTRY_BYTES  = 8;
   localparam int DEF_MAX_SLOTS    = 512;

   localparam int OP_W   = 3;
   localparam int SLOT_W = 9;
   localparam int LEN_W  = 13;

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_RESIZE = 3'd3;
   localparam logic [OP_W-1:0] OP_GET    = 3'd4;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;

   typedef struct packed {
      logic [LEN_W-1:0]  move_length;
      logic [LEN_W-1:0]  move_dest;
      logic [LEN_W-1:0]  move_source;
      logic              move_valid;
      logic              record_live;
      logic [LEN_W-1:0]  record_size;
      logic [LEN_W-1:0]  record_offset;
      logic [SLOT_W-1:0] result_slot;
      logic              status;
   } rsp_type;

endpackage

FILE: rtl/core/slotted_page_manager.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slotted_page_manager
// Slot directory keeper of one page, with a registered response word.
// ---------------------------------------------------------------------------
// channel | direction | ports        | word
// req     | in        | req_t*       | opcode, slot_index, record_length
// rsp     | out       | rsp_t*       | status .. move_length, one per req word
//
// Clear, create, get and failures pass the look, check and done states on
// their way to the response register. Delete and resize also walk the
// directory memory, one entry read per cycle, moved entries written back, then the target.
// Reset is synchronous; the directory memory needs no clearing pass.
// A new req word is taken while a response still waits on rsp_tready.
module slotted_page_manager
   import pgm_pkg::*;
#(
   parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES,
   parameter int ENTRY_BYTES  = DEF_ENTRY_BYTES,
   parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode[2:0], slot_index[11:3], record_length[24:12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[0], result_slot[9:1], record_offset[22:10], record_size[35:23],
   // record_live[36], move_valid[37], move_source[50:38], move_dest[63:51],
   // move_length[76:64]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int PW = $clog2(PAGE_BYTES + 1);
   localparam int W  = (PW > LEN_W) ? PW : LEN_W;
   localparam int SW = $clog2(MAX_SLOTS);
   localparam int EW = 2 * W + 1;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          out_free, done;
   rsp_type       result;
   logic          rd_en, wr_en;
   logic [SW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] rd_data, wr_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   pgm_ctrl #(
      .PAGE_BYTES   (PAGE_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .ENTRY_BYTES  (ENTRY_BYTES),
      .MAX_SLOTS    (MAX_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tdata[2:0]),
      .req_slot   (req_tdata[11:3]),
      .req_length (req_tdata[24:12]),
      .out_free   (out_free),
      .done       (done),
      .result     (result),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   pgm_dir_ram #(
      .DEPTH (MAX_SLOTS),
      .WIDTH (EW)
   ) u_dir_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_data_ff};

endmodule

FILE: rtl/core/pgm_dir_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pgm_dir_ram
// Slot directory memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module pgm_dir_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 27
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pgm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pgm_ctrl
// Opcode sequencer: checks, directory walk and write-back of the target.
// ---------------------------------------------------------------------------
module pgm_ctrl
   import pgm_pkg::*;
#(
   parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES,
   parameter int ENTRY_BYTES  = DEF_ENTRY_BYTES,
   parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
   localparam int PW = $clog2(PAGE_BYTES + 1),
   localparam int W  = (PW > LEN_W) ? PW : LEN_W,
   localparam int SW = $clog2(MAX_SLOTS),
   localparam int EW = 2 * W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [LEN_W-1:0]  req_length,
   input  logic              out_free,
   output logic              done,
   output rsp_type           result,
   output logic              rd_en,
   output logic [SW-1:0]     rd_addr,
   input  logic [EW-1:0]     rd_data,
   output logic              wr_en,
   output logic [SW-1:0]     wr_addr,
   output logic [EW-1:0]     wr_data
);

   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int DW = W + CW + $clog2(ENTRY_BYTES + 1) + 3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_TGT   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [W-1:0]      len_ff, len_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [W-1:0]      fp_ff, fp_in;
   rsp_type           res_ff, res_in;
   logic [W-1:0]      delta_ff, delta_in;
   logic [W-1:0]      limit_ff, limit_in;
   logic [EW-1:0]     tgt_ff, tgt_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [SW-1:0]     paddr_ff, paddr_in;

   logic [W-1:0]  e_off, e_len, region, grow, shrink;
   logic          e_live, bad, mv;
   logic [DW-1:0] dir, room;

   assign e_off  = rd_data[W-1:0];
   assign e_len  = rd_data[2*W-1:W];
   assign e_live = rd_data[2*W];
   assign dir    = DW'(HEADER_BYTES) + DW'(ENTRY_BYTES) * DW'(count_ff);
   assign region = (e_off >= fp_ff) ? e_off - fp_ff : '0;
   assign grow   = len_ff - e_len;
   assign shrink = e_len - len_ff;
   assign room   = (DW'(fp_ff) > dir) ? DW'(fp_ff) - dir : '0;
   assign bad    = (op_ff > OP_GET) || (DW'(idx_ff) >= DW'(count_ff)) || !e_live;
   assign mv     = (region != '0);

   assign req_ready = (state_ff == ST_IDLE);
   assign result    = res_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      count_in = count_ff;
      fp_in    = fp_ff;
      res_in   = res_ff;
      delta_in = delta_ff;
      limit_in = limit_ff;
      tgt_in   = tgt_ff;
      scan_in  = scan_ff;
      pend_in  = 1'b0;
      paddr_in = paddr_ff;
      rd_en    = 1'b0;
      rd_addr  = SW'(idx_ff);
      wr_en    = 1'b0;
      wr_addr  = SW'(idx_ff);
      wr_data  = tgt_ff;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               idx_in   = req_slot;
               len_in   = W'(req_length);
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            res_in   = '0;
            state_in = ST_DONE;
            if (op_ff == OP_CLEAR) begin
               count_in = '0;
               fp_in    = W'(PAGE_BYTES);
            end else if (op_ff == OP_CREATE) begin
               if (DW'(count_ff) >= DW'(MAX_SLOTS) ||
                   dir + DW'(ENTRY_BYTES) + DW'(len_ff) > DW'(fp_ff)) begin
                  res_in.status = 1'b1;
               end else begin
                  fp_in    = fp_ff - len_ff;
                  wr_en    = 1'b1;
                  wr_addr  = SW'(count_ff);
                  wr_data  = {1'b1, len_ff, fp_ff - len_ff};
                  count_in = count_ff + 1'b1;
                  res_in.result_slot   = SLOT_W'(count_ff);
                  res_in.record_offset = LEN_W'(fp_ff - len_ff);
                  res_in.record_size   = LEN_W'(len_ff);
                  res_in.record_live   = 1'b1;
               end
            end else if (bad) begin
               res_in.status = 1'b1;
            end else if (op_ff == OP_GET) begin
               res_in.record_offset = LEN_W'(e_off);
               res_in.record_size   = LEN_W'(e_len);
               res_in.record_live   = 1'b1;
            end else if (op_ff == OP_DELETE) begin
               res_in.move_valid = mv && (e_len != '0);
               if (mv && (e_len != '0)) begin
                  res_in.move_source = LEN_W'(fp_ff);
                  res_in.move_dest   = LEN_W'(fp_ff + e_len);
                  res_in.move_length = LEN_W'(region);
               end
               delta_in = e_len;
               limit_in = e_off;
               fp_in    = fp_ff + e_len;
               tgt_in   = '0;
               scan_in  = '0;
               state_in = ST_SWEEP;
            end else if (len_ff > e_len) begin
               if (DW'(grow) > room) begin
                  res_in.status = 1'b1;
               end else begin
                  res_in.move_valid = mv;
                  if (mv) begin
                     res_in.move_source = LEN_W'(fp_ff);
                     res_in.move_dest   = LEN_W'(fp_ff - grow);
                     res_in.move_length = LEN_W'(region);
                  end
                  res_in.record_offset = LEN_W'(e_off - grow);
                  res_in.record_size   = LEN_W'(len_ff);
                  res_in.record_live   = 1'b1;
                  delta_in = '0 - grow;
                  limit_in = e_off;
                  fp_in    = fp_ff - grow;
                  tgt_in   = {1'b1, len_ff, e_off - grow};
                  scan_in  = '0;
                  state_in = ST_SWEEP;
               end
            end else begin
               res_in.move_valid = mv && (shrink != '0);
               if (mv && (shrink != '0)) begin
                  res_in.move_source = LEN_W'(fp_ff);
                  res_in.move_dest   = LEN_W'(fp_ff + shrink);
                  res_in.move_length = LEN_W'(region);
               end
               res_in.record_offset = LEN_W'(e_off + shrink);
               res_in.record_size   = LEN_W'(len_ff);
               res_in.record_live   = 1'b1;
               delta_in = shrink;
               limit_in = e_off;
               fp_in    = fp_ff + shrink;
               tgt_in   = {1'b1, len_ff, e_off + shrink};
               scan_in  = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (scan_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = SW'(scan_ff);
               pend_in  = 1'b1;
               paddr_in = SW'(scan_ff);
               scan_in  = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_TGT;
            end
            if (pend_ff && e_live && (e_off < limit_ff)) begin
               wr_en   = 1'b1;
               wr_addr = paddr_ff;
               wr_data = {e_live, e_len, e_off + delta_ff};
            end
         end
         ST_TGT: begin
            wr_en    = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         fp_ff    <= W'(PAGE_BYTES);
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fp_ff    <= fp_in;
         pend_ff  <= pend_in;
      end
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      res_ff   <= res_in;
      delta_ff <= delta_in;
      limit_ff <= limit_in;
      tgt_ff   <= tgt_in;
      scan_ff  <= scan_in;
      paddr_ff <= paddr_in;
   end

`ifndef SYNTHESIS
   a_count_max : assert property (@(posedge clock) disable iff (reset)
      DW'(count_ff) <= DW'(MAX_SLOTS))
      else $error("slot count beyond directory size");
   a_fp_max : assert property (@(posedge clock) disable iff (reset)
      DW'(fp_ff) <= DW'(PAGE_BYTES))
      else $error("free pointer beyond page end");
   a_sweep_addr : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && wr_en) |-> (DW'(wr_addr) < DW'(count_ff)))
      else $error("walk writes outside the directory");
   a_done_free : assert property (@(posedge clock) disable iff (reset)
      done |-> (out_free && state_ff == ST_DONE))
      else $error("result issued while output busy");
   a_pend_sweep : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SWEEP))
      else $error("pending walk read outside walk");
`endif

endmodule
